>>> sv/mtep_pkg.sv
package mtep_pkg;

  localparam int VarintBytesDflt = 4;
  localparam int AccW = 28;
  localparam int CntW = 3;

  // parser phases, one-hot
  typedef enum logic [7:0] {
    PH_DELTA   = 8'b0000_0001,
    PH_STATUS  = 8'b0000_0010,
    PH_D1      = 8'b0000_0100,
    PH_D2      = 8'b0000_1000,
    PH_SXLEN   = 8'b0001_0000,
    PH_MTYPE   = 8'b0010_0000,
    PH_MLEN    = 8'b0100_0000,
    PH_PAYLOAD = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_CC       = 3'd2,
    KIND_SYSEX_F0 = 3'd3,
    KIND_SYSEX_F7 = 3'd4,
    KIND_META     = 3'd5,
    KIND_PAYLOAD  = 3'd6,
    KIND_ERROR    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ERR_TRUNCATED  = 2'd0,
    ERR_NO_RUNNING = 2'd1,
    ERR_UNSUPPORTED = 2'd2,
    ERR_VARINT_LONG = 2'd3
  } err_t;

  localparam logic [7:0] ST_SYSEX_F0 = 8'hF0;
  localparam logic [7:0] ST_SYSEX_F7 = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_CC       = 4'hB;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_first;
    logic       track_last;
  } in_item_t;

  typedef struct packed {
    kind_t          kind;
    logic [AccW-1:0] delta_ticks;
    logic [3:0]     channel;
    logic [7:0]     first_data;
    logic [7:0]     second_data;
    logic [7:0]     meta_kind;
    logic [AccW-1:0] payload_length;
    logic [7:0]     payload_value;
    logic           payload_end;
    err_t           error_code;
  } res_t;

  function automatic logic is_channel(input logic [7:0] s);
    is_channel = (s[7:4] == HI_NOTE_OFF) || (s[7:4] == HI_NOTE_ON) || (s[7:4] == HI_CC);
  endfunction

endpackage

>>> sv/mtep_if.sv
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_first;
  logic       track_last;

  modport source(output valid, output data_byte, output track_first, output track_last,
                 input ready);
  modport sink(input valid, input data_byte, input track_first, input track_last,
               output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [27:0] delta_ticks;
  logic [3:0]  channel;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [7:0]  meta_kind;
  logic [27:0] payload_length;
  logic [7:0]  payload_value;
  logic        payload_end;
  logic [1:0]  error_code;

  modport source(output valid, output kind, output delta_ticks, output channel,
                 output first_data, output second_data, output meta_kind,
                 output payload_length, output payload_value, output payload_end,
                 output error_code, input ready);
  modport sink(input valid, input kind, input delta_ticks, input channel,
               input first_data, input second_data, input meta_kind,
               input payload_length, input payload_value, input payload_end,
               input error_code, output ready);
endinterface

>>> sv/mtep_in_reg.sv
module mtep_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtep_pkg::in_item_t in_item,
  input  logic              take,
  output logic              item_vld,
  output mtep_pkg::in_item_t item
);

  logic               vld_r, vld_nxt;
  mtep_pkg::in_item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_valid ? 1'b1 : (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> sv/mtep_core.sv
module mtep_core #(
  parameter int VARINT_BYTES = mtep_pkg::VarintBytesDflt
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  mtep_pkg::in_item_t item,
  output logic               res_vld,
  output mtep_pkg::res_t     res,
  output logic               halted
);

  localparam int AccW = mtep_pkg::AccW;
  localparam int CntW = mtep_pkg::CntW;

  mtep_pkg::phase_t phase_r, phase_nxt, e_phase;
  logic [7:0]       last_r, last_nxt, e_last;
  logic [AccW-1:0]  delta_r, delta_nxt, e_delta;
  logic [CntW-1:0]  cnt_r, cnt_nxt, e_cnt, cnt_inc;
  logic [AccW-1:0]  len_r, len_nxt, e_len;
  logic [7:0]       held_r, held_nxt, e_held;
  logic [7:0]       mtype_r, mtype_nxt, e_mtype;
  logic             halt_r, halt_nxt, e_halt;
  logic [AccW-1:0]  vsrc, vacc;
  logic             vlong;
  logic [7:0]       b;

  always_comb begin
    b = item.data_byte;
    // start of track behaves like a reset ahead of the byte
    if (item.track_first) begin
      e_phase = mtep_pkg::PH_DELTA;
      e_last  = '0;
      e_delta = '0;
      e_cnt   = '0;
      e_len   = '0;
      e_held  = '0;
      e_mtype = '0;
      e_halt  = 1'b0;
    end else begin
      e_phase = phase_r;
      e_last  = last_r;
      e_delta = delta_r;
      e_cnt   = cnt_r;
      e_len   = len_r;
      e_held  = held_r;
      e_mtype = mtype_r;
      e_halt  = halt_r;
    end

    phase_nxt = e_phase;
    last_nxt  = e_last;
    delta_nxt = e_delta;
    cnt_nxt   = e_cnt;
    len_nxt   = e_len;
    held_nxt  = e_held;
    mtype_nxt = e_mtype;
    halt_nxt  = e_halt;
    res       = '0;
    res_vld   = 1'b0;

    // shared varint step for delta time and length
    if (e_phase == mtep_pkg::PH_DELTA) begin
      vsrc = (e_cnt == '0) ? '0 : e_delta;
    end else begin
      vsrc = e_len;
    end
    vacc    = {vsrc[AccW-8:0], b[6:0]};
    cnt_inc = e_cnt + CntW'(1);
    vlong   = (int'(cnt_inc) >= VARINT_BYTES);

    if (!e_halt) begin
      unique case (e_phase)
        mtep_pkg::PH_DELTA: begin
          delta_nxt = vacc;
          if (b[7]) begin
            cnt_nxt = cnt_inc;
            if (vlong) begin
              res_vld          = 1'b1;
              res.kind         = mtep_pkg::KIND_ERROR;
              res.error_code   = mtep_pkg::ERR_VARINT_LONG;
              halt_nxt         = 1'b1;
            end
          end else begin
            cnt_nxt   = '0;
            phase_nxt = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (b[7]) begin
            last_nxt = b;
            if (mtep_pkg::is_channel(b)) begin
              phase_nxt = mtep_pkg::PH_D1;
            end else if (b == mtep_pkg::ST_SYSEX_F0 || b == mtep_pkg::ST_SYSEX_F7) begin
              len_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = mtep_pkg::PH_SXLEN;
            end else if (b == mtep_pkg::ST_META) begin
              phase_nxt = mtep_pkg::PH_MTYPE;
            end else begin
              res_vld        = 1'b1;
              res.kind       = mtep_pkg::KIND_ERROR;
              res.error_code = mtep_pkg::ERR_UNSUPPORTED;
              halt_nxt       = 1'b1;
            end
          end else if (mtep_pkg::is_channel(e_last)) begin
            held_nxt  = b;
            phase_nxt = mtep_pkg::PH_D2;
          end else begin
            res_vld        = 1'b1;
            res.kind       = mtep_pkg::KIND_ERROR;
            res.error_code = mtep_pkg::ERR_NO_RUNNING;
            halt_nxt       = 1'b1;
          end
        end
        mtep_pkg::PH_D1: begin
          held_nxt  = b;
          phase_nxt = mtep_pkg::PH_D2;
        end
        mtep_pkg::PH_D2: begin
          res_vld = 1'b1;
          if (e_last[7:4] == mtep_pkg::HI_NOTE_OFF) begin
            res.kind = mtep_pkg::KIND_NOTE_OFF;
          end else if (e_last[7:4] == mtep_pkg::HI_NOTE_ON) begin
            res.kind = mtep_pkg::KIND_NOTE_ON;
          end else begin
            res.kind = mtep_pkg::KIND_CC;
          end
          res.delta_ticks = e_delta;
          res.channel     = e_last[3:0];
          res.first_data  = e_held;
          res.second_data = b;
          phase_nxt       = mtep_pkg::PH_DELTA;
        end
        mtep_pkg::PH_SXLEN, mtep_pkg::PH_MLEN: begin
          len_nxt = vacc;
          if (b[7]) begin
            cnt_nxt = cnt_inc;
            if (vlong) begin
              res_vld        = 1'b1;
              res.kind       = mtep_pkg::KIND_ERROR;
              res.error_code = mtep_pkg::ERR_VARINT_LONG;
              halt_nxt       = 1'b1;
            end
          end else begin
            cnt_nxt            = '0;
            res_vld            = 1'b1;
            res.delta_ticks    = e_delta;
            res.payload_length = vacc;
            if (e_phase == mtep_pkg::PH_MLEN) begin
              res.kind      = mtep_pkg::KIND_META;
              res.meta_kind = e_mtype;
            end else if (e_last == mtep_pkg::ST_SYSEX_F0) begin
              res.kind = mtep_pkg::KIND_SYSEX_F0;
            end else begin
              res.kind = mtep_pkg::KIND_SYSEX_F7;
            end
            phase_nxt = (vacc == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
          end
        end
        mtep_pkg::PH_MTYPE: begin
          mtype_nxt = b;
          len_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = mtep_pkg::PH_MLEN;
        end
        mtep_pkg::PH_PAYLOAD: begin
          res_vld           = 1'b1;
          res.kind          = mtep_pkg::KIND_PAYLOAD;
          res.delta_ticks   = e_delta;
          res.payload_value = b;
          res.payload_end   = (e_len == AccW'(1));
          len_nxt           = e_len - AccW'(1);
          if (len_nxt == '0) begin
            phase_nxt = mtep_pkg::PH_DELTA;
          end
        end
        default: begin
          phase_nxt = mtep_pkg::PH_DELTA;
          cnt_nxt   = '0;
        end
      endcase

      // end of chunk: an event cut off gives a truncation error, and the parser halts
      if (item.track_last) begin
        if (!halt_nxt && !(phase_nxt == mtep_pkg::PH_DELTA && cnt_nxt == '0)) begin
          res            = '0;
          res_vld        = 1'b1;
          res.kind       = mtep_pkg::KIND_ERROR;
          res.error_code = mtep_pkg::ERR_TRUNCATED;
        end
        halt_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mtep_pkg::PH_DELTA;
      last_r  <= '0;
      delta_r <= '0;
      cnt_r   <= '0;
      len_r   <= '0;
      held_r  <= '0;
      mtype_r <= '0;
      halt_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      delta_r <= delta_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      held_r  <= held_nxt;
      mtype_r <= mtype_nxt;
      halt_r  <= halt_nxt;
    end
  end

  assign halted = halt_r;

endmodule

>>> sv/mtep_out_reg.sv
module mtep_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic           res_vld,
  input  mtep_pkg::res_t res,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output mtep_pkg::res_t out_res
);

  logic           vld_r, vld_nxt;
  mtep_pkg::res_t res_r;

  assign slot_free = !vld_r || out_ready;

  always_comb begin
    if (take) begin
      vld_nxt = res_vld;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

>>> sv/midi_track_event_parser.sv
// Standard MIDI file track event parser, one track-chunk byte per request.
// in_bus carries data_byte with track_first / track_last marks; out_bus carries
// one event header, one sysex/meta payload byte, or one error per result.
// Both channels use valid/ready; a request moves when both are high.
// A byte is held in an input register, decoded and its result
// (if any) written to the output register, which drives out_bus. Throughput
// is one byte per cycle while out_bus does not stall.
// Bytes that give no result (delta time, status, first data byte) still
// wait for a free output register before they are decoded.
// When out_bus stalls, the output register holds its result and the input
// register still takes one more byte; after that in_bus.ready follows
// out_bus.ready.
// Reset (synchronous, rst_n low) empties both registers and returns the
// parser to expecting a delta time with no running status. After an error or
// the last byte of a track the parser ignores bytes until track_first.
module midi_track_event_parser #(
  parameter int VARINT_BYTES = mtep_pkg::VarintBytesDflt
) (
  input  logic        clk,
  input  logic        rst_n,
  mtep_in_if.sink     in_bus,
  mtep_out_if.source  out_bus
);

  mtep_pkg::in_item_t in_item, item;
  mtep_pkg::res_t     res, out_res;
  logic               item_vld, slot_free, take, res_vld, halted;

  assign in_item.data_byte   = in_bus.data_byte;
  assign in_item.track_first = in_bus.track_first;
  assign in_item.track_last  = in_bus.track_last;

  assign take = item_vld && slot_free;

  mtep_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_item  (in_item),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  mtep_core #(
    .VARINT_BYTES (VARINT_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .item    (item),
    .res_vld (res_vld),
    .res     (res),
    .halted  (halted)
  );

  mtep_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res_vld   (res_vld),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  assign out_bus.kind           = out_res.kind;
  assign out_bus.delta_ticks    = out_res.delta_ticks;
  assign out_bus.channel        = out_res.channel;
  assign out_bus.first_data     = out_res.first_data;
  assign out_bus.second_data    = out_res.second_data;
  assign out_bus.meta_kind      = out_res.meta_kind;
  assign out_bus.payload_length = out_res.payload_length;
  assign out_bus.payload_value  = out_res.payload_value;
  assign out_bus.payload_end    = out_res.payload_end;
  assign out_bus.error_code     = out_res.error_code;

  // a halted parser without a new track gives no result
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    take && halted && !item.track_first |-> !res_vld)
    else $error("result produced while halted");

  // errors always leave the parser halted
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_vld && res.kind == mtep_pkg::KIND_ERROR |=> halted)
    else $error("error did not halt parser");

  // payload end only on payload results
  a_pend_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.payload_end |-> out_bus.kind == mtep_pkg::KIND_PAYLOAD)
    else $error("payload_end on non-payload result");

  // no result appears without a byte taken the cycle before
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(take))
    else $error("result without a decoded byte");

endmodule

>>> test/midi_track_event_parser_test.sv
`timescale 1ns / 100ps

class track_scoreboard;
  typedef enum {VI_MORE, VI_DONE, VI_LONG} varint_step_t;
  localparam int VarintLimit = mtep_pkg::VarintBytesDflt;

  mtep_pkg::phase_t phase;
  logic [7:0]  run_status;
  logic [27:0] delta_acc;
  logic [27:0] len_acc;
  int unsigned vcount;
  logic [7:0]  held_data;
  logic [7:0]  held_meta;
  bit          halted;

  mtep_pkg::res_t awaited[$];
  int   failures;
  int   checked;
  int   n_head;
  int   n_payload;
  int   n_err;

  function new();
    clear();
  endfunction

  function void clear();
    phase      = mtep_pkg::PH_DELTA;
    run_status = '0;
    delta_acc  = '0;
    len_acc    = '0;
    vcount     = 0;
    held_data  = '0;
    held_meta  = '0;
    halted     = 1'b0;
  endfunction

  function bit is_voice(logic [7:0] s);
    return s[7:4] == mtep_pkg::HI_NOTE_OFF || s[7:4] == mtep_pkg::HI_NOTE_ON ||
           s[7:4] == mtep_pkg::HI_CC;
  endfunction

  function varint_step_t varint_step(input logic [27:0] acc_in, input logic [7:0] b,
                                     output logic [27:0] acc_out);
    acc_out = {acc_in[20:0], b[6:0]};
    if (b[7]) begin
      vcount++;
      return (vcount >= VarintLimit) ? VI_LONG : VI_MORE;
    end
    vcount = 0;
    return VI_DONE;
  endfunction

  function mtep_pkg::res_t halt_with(mtep_pkg::err_t code);
    mtep_pkg::res_t r;
    halted = 1'b1;
    r = '0;
    r.kind = mtep_pkg::KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  // one accepted request: update the parser copy and queue what it yields
  function void note_byte(mtep_pkg::in_item_t it);
    mtep_pkg::res_t r;
    bit           got;
    varint_step_t vs;
    logic [7:0]   b;
    logic [3:0]   hi;
    b = it.data_byte;
    r = '0;
    got = 1'b0;
    if (it.track_first) clear();
    if (halted) return;
    case (phase)
      mtep_pkg::PH_DELTA: begin
        if (vcount == 0) delta_acc = '0;
        vs = varint_step(delta_acc, b, delta_acc);
        if (vs == VI_LONG) begin
          r = halt_with(mtep_pkg::ERR_VARINT_LONG);
          got = 1'b1;
        end else if (vs == VI_DONE) begin
          phase = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (b[7]) begin
          run_status = b;
          if (is_voice(b)) begin
            phase = mtep_pkg::PH_D1;
          end else if (b == mtep_pkg::ST_SYSEX_F0 || b == mtep_pkg::ST_SYSEX_F7) begin
            len_acc = '0;
            vcount = 0;
            phase = mtep_pkg::PH_SXLEN;
          end else if (b == mtep_pkg::ST_META) begin
            phase = mtep_pkg::PH_MTYPE;
          end else begin
            r = halt_with(mtep_pkg::ERR_UNSUPPORTED);
            got = 1'b1;
          end
        end else if (is_voice(run_status)) begin
          held_data = b;
          phase = mtep_pkg::PH_D2;
        end else begin
          r = halt_with(mtep_pkg::ERR_NO_RUNNING);
          got = 1'b1;
        end
      end
      mtep_pkg::PH_D1: begin
        held_data = b;
        phase = mtep_pkg::PH_D2;
      end
      mtep_pkg::PH_D2: begin
        hi = run_status[7:4];
        r.kind = (hi == mtep_pkg::HI_NOTE_OFF) ? mtep_pkg::KIND_NOTE_OFF :
                 (hi == mtep_pkg::HI_NOTE_ON) ? mtep_pkg::KIND_NOTE_ON : mtep_pkg::KIND_CC;
        r.delta_ticks = delta_acc;
        r.channel = run_status[3:0];
        r.first_data = held_data;
        r.second_data = b;
        got = 1'b1;
        phase = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_SXLEN, mtep_pkg::PH_MLEN: begin
        vs = varint_step(len_acc, b, len_acc);
        if (vs == VI_LONG) begin
          r = halt_with(mtep_pkg::ERR_VARINT_LONG);
          got = 1'b1;
        end else if (vs == VI_DONE) begin
          r.delta_ticks = delta_acc;
          r.payload_length = len_acc;
          if (phase == mtep_pkg::PH_MLEN) begin
            r.kind = mtep_pkg::KIND_META;
            r.meta_kind = held_meta;
          end else begin
            r.kind = (run_status == mtep_pkg::ST_SYSEX_F0) ? mtep_pkg::KIND_SYSEX_F0
                                                          : mtep_pkg::KIND_SYSEX_F7;
          end
          got = 1'b1;
          phase = (len_acc == 0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
        end
      end
      mtep_pkg::PH_MTYPE: begin
        held_meta = b;
        len_acc = '0;
        vcount = 0;
        phase = mtep_pkg::PH_MLEN;
      end
      mtep_pkg::PH_PAYLOAD: begin
        r.kind = mtep_pkg::KIND_PAYLOAD;
        r.delta_ticks = delta_acc;
        r.payload_value = b;
        r.payload_end = (len_acc == 1);
        got = 1'b1;
        len_acc = len_acc - 1'b1;
        if (len_acc == 0) phase = mtep_pkg::PH_DELTA;
      end
      default: begin
        phase = mtep_pkg::PH_DELTA;
        vcount = 0;
      end
    endcase
    // an event cut off by the end of the track turns into a truncation error; either way it halts
    if (it.track_last) begin
      if (!halted && !(phase == mtep_pkg::PH_DELTA && vcount == 0)) begin
        r = halt_with(mtep_pkg::ERR_TRUNCATED);
        got = 1'b1;
      end
      halted = 1'b1;
    end
    if (got) awaited.push_back(r);
  endfunction

  function string show(mtep_pkg::res_t r);
    return {$sformatf("kind=%0d delta=%0d ch=%0d d1=%02h d2=%02h ",
                      r.kind, r.delta_ticks, r.channel, r.first_data, r.second_data),
            $sformatf("meta=%02h len=%0d pv=%02h end=%0b err=%0d",
                      r.meta_kind, r.payload_length, r.payload_value, r.payload_end,
                      r.error_code)};
  endfunction

  function void check_result(mtep_pkg::res_t seen);
    mtep_pkg::res_t want;
    bit   bad;
    if (awaited.size() == 0) begin
      failures++;
      if (failures <= 10) $display("result with nothing pending: %s", show(seen));
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (want.kind == mtep_pkg::KIND_PAYLOAD) n_payload++;
    else if (want.kind == mtep_pkg::KIND_ERROR) n_err++;
    else n_head++;
    bad = (seen.kind !== want.kind) || (seen.delta_ticks !== want.delta_ticks) ||
          (seen.channel !== want.channel) || (seen.first_data !== want.first_data) ||
          (seen.second_data !== want.second_data) || (seen.meta_kind !== want.meta_kind) ||
          (seen.payload_length !== want.payload_length) ||
          (seen.payload_value !== want.payload_value) ||
          (seen.payload_end !== want.payload_end) || (seen.error_code !== want.error_code);
    if (bad) begin
      failures++;
      if (failures <= 10) begin
        $display("mismatch at result %0d", checked);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(seen));
      end
    end
  endfunction
endclass

module midi_track_event_parser_test;
  localparam int VarintLimit = mtep_pkg::VarintBytesDflt;
  localparam int CycleLimit = 200000;
  localparam int RandomBytes = 420;
  localparam int LongHold = 80;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  mtep_in_if  in_if ();
  mtep_out_if out_if ();

  midi_track_event_parser #(.VARINT_BYTES(VarintLimit)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  track_scoreboard    book = new();
  mtep_pkg::in_item_t track_buf[$];
  bit              quiet = 1'b0;
  bit              hold_out = 1'b0;
  int              sent_bytes = 0;
  int              n_tracks = 0;
  int unsigned     cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL midi_track_event_parser");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic mtep_pkg::res_t seen_result();
    mtep_pkg::res_t r;
    r.kind           = mtep_pkg::kind_t'(out_if.kind);
    r.delta_ticks    = out_if.delta_ticks;
    r.channel        = out_if.channel;
    r.first_data     = out_if.first_data;
    r.second_data    = out_if.second_data;
    r.meta_kind      = out_if.meta_kind;
    r.payload_length = out_if.payload_length;
    r.payload_value  = out_if.payload_value;
    r.payload_end    = out_if.payload_end;
    r.error_code     = mtep_pkg::err_t'(out_if.error_code);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) book.check_result(seen_result());
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_out = 1'b0;
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic void put(logic [7:0] b);
    mtep_pkg::in_item_t it;
    it.data_byte = b;
    it.track_first = 1'b0;
    it.track_last = 1'b0;
    track_buf.push_back(it);
  endfunction

  function automatic void put_varint(logic [27:0] v, int min_bytes);
    int n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    if (min_bytes > n) n = min_bytes;
    for (int i = n - 1; i >= 0; i--) put({(i != 0), v[7 * i +: 7]});
  endfunction

  function automatic logic [27:0] rand_span();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return '0;
    if (p < 75) return 28'($urandom_range(1, 127));
    if (p < 92) return 28'($urandom_range(128, 16383));
    if (p < 97) return 28'($urandom_range(16384, 28'h0FFFFFFF));
    return 28'h0FFFFFFF;
  endfunction

  function automatic void put_delta();
    put_varint(rand_span(), ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 1);
  endfunction

  function automatic logic [7:0] data_val();
    return ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] voice_status();
    logic [3:0] hi;
    case ($urandom_range(0, 2))
      0: hi = mtep_pkg::HI_NOTE_OFF;
      1: hi = mtep_pkg::HI_NOTE_ON;
      default: hi = mtep_pkg::HI_CC;
    endcase
    return {hi, 4'($urandom_range(0, 15))};
  endfunction

  function automatic logic [7:0] bad_status();
    logic [7:0] b;
    do b = 8'($urandom_range(128, 255));
    while (b[7:4] == mtep_pkg::HI_NOTE_OFF || b[7:4] == mtep_pkg::HI_NOTE_ON ||
           b[7:4] == mtep_pkg::HI_CC || b == mtep_pkg::ST_SYSEX_F0 ||
           b == mtep_pkg::ST_SYSEX_F7 || b == mtep_pkg::ST_META);
    return b;
  endfunction

  // length and payload of a sysex or meta event; 1 when the track must end here
  function automatic bit put_body();
    int          p;
    logic [27:0] len;
    int          pay;
    p = $urandom_range(0, 99);
    if (p < 15) len = '0;
    else if (p < 75) len = 28'($urandom_range(1, 4));
    else if (p < 93) len = 28'($urandom_range(5, 20));
    else if (p < 97) begin
      repeat (4) put(8'h80 | 8'($urandom_range(0, 127)));
      return 1'b1;
    end else len = (p == 99) ? 28'h0FFFFFFF : 28'($urandom_range(21, 28'h0FFFFFFF));
    put_varint(len, ($urandom_range(0, 7) == 0) ? 4 : 1);
    // huge lengths get a few bytes and then the track is cut short
    pay = (len > 20) ? 3 : int'(len);
    repeat (pay) put(8'($urandom_range(0, 255)));
    return len > 20;
  endfunction

  function automatic void finish_track();
    track_buf[0].track_first = 1'b1;
    track_buf[track_buf.size() - 1].track_last = 1'b1;
  endfunction

  function automatic void build_random_track();
    int n_ev;
    int p;
    int cut;
    bit chan_ok;
    bit stop;
    n_ev = $urandom_range(1, 10);
    chan_ok = 1'b0;
    stop = 1'b0;
    for (int e = 0; e < n_ev && !stop; e++) begin
      if ($urandom_range(0, 29) == 0) begin
        repeat (4) put(8'h80 | 8'($urandom_range(0, 127)));
        stop = 1'b1;
      end else begin
        put_delta();
        p = $urandom_range(0, 99);
        if (p < 45) begin
          if (!(chan_ok && $urandom_range(0, 2) == 0)) put(voice_status());
          put(data_val());
          put(data_val());
          chan_ok = 1'b1;
        end else if (p < 60) begin
          put(($urandom_range(0, 1) == 0) ? mtep_pkg::ST_SYSEX_F0 : mtep_pkg::ST_SYSEX_F7);
          stop = put_body();
          chan_ok = 1'b0;
        end else if (p < 85) begin
          put(mtep_pkg::ST_META);
          put(($urandom_range(0, 3) == 0) ? 8'h2F : 8'($urandom_range(0, 255)));
          stop = put_body();
          chan_ok = 1'b0;
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              put(bad_status());
              stop = 1'b1;
            end
            1: begin
              // data byte where a status belongs: fine only with running status
              put(8'($urandom_range(0, 127)));
              if (chan_ok) put(data_val());
              else stop = 1'b1;
            end
            default: begin
              put(8'($urandom_range(0, 255)));
              stop = 1'b1;
            end
          endcase
        end
      end
    end
    if (!stop) begin
      if ($urandom_range(0, 4) != 0) begin
        put_delta();
        put(mtep_pkg::ST_META);
        put(8'h2F);
        put(8'h00);
      end else begin
        cut = $urandom_range(1, track_buf.size());
        while (track_buf.size() > cut) void'(track_buf.pop_back());
      end
    end
    finish_track();
    if (track_buf.size() > 2 && $urandom_range(0, 19) == 0)
      track_buf[$urandom_range(1, track_buf.size() - 1)].track_first = 1'b1;
    // stray bytes after the end of a track are ignored
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
  endfunction

  task automatic push_byte(mtep_pkg::in_item_t it);
    in_if.valid <= 1'b1;
    in_if.data_byte <= it.data_byte;
    in_if.track_first <= it.track_first;
    in_if.track_last <= it.track_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    book.note_byte(it);
    sent_bytes++;
  endtask

  task automatic send_track();
    int n;
    foreach (track_buf[i]) begin
      push_byte(track_buf[i]);
      n = gap_len();
      if (n > 0) begin
        in_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
    track_buf.delete();
    n_tracks++;
  endtask

  task automatic send_fixed(input logic [7:0] seq[$]);
    foreach (seq[i]) put(seq[i]);
    finish_track();
    send_track();
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk);
    while (book.awaited.size() != 0);
  endtask

  initial begin
    int rand_sent;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.track_first <= 1'b0;
    in_if.track_last <= 1'b0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest delta, every event type, 8-bit data, running status, sysex with payload
    send_fixed('{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h9F, 8'h00, 8'hFF,
                 8'h00, 8'h80, 8'h80, 8'h7F, 8'h00, 8'h12, 8'h34,
                 8'h00, 8'hB0, 8'h01, 8'h02, 8'h00, 8'hF0, 8'h01, 8'hAA,
                 8'h00, 8'hF7, 8'h00, 8'h00, 8'hFF, 8'h2F, 8'h00});
    // data byte with no running status, then a byte while halted
    send_fixed('{8'h00, 8'h45, 8'h01});
    // delta varint one byte too long
    send_fixed('{8'h80, 8'h80, 8'h80, 8'h80});
    // unsupported status
    send_fixed('{8'h00, 8'hC5});
    // track ends where a meta header with pending payload would come
    send_fixed('{8'h00, 8'hFF, 8'h03, 8'h02});
    drain();

    rand_sent = 0;
    while (rand_sent < RandomBytes) begin
      build_random_track();
      rand_sent += track_buf.size();
      quiet = ($urandom_range(0, 3) == 0);
      if (n_tracks == 6) begin
        // result side stalls long while requests keep coming
        quiet = 1'b1;
        hold_out = 1'b1;
      end
      send_track();
      if (n_tracks == 10) drain();
    end
    quiet = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("sent %0d bytes in %0d tracks; checked %0d results", sent_bytes, n_tracks,
             book.checked);
    $display("  %0d event headers, %0d payload bytes, %0d errors", book.n_head,
             book.n_payload, book.n_err);
    if (book.failures == 0 && book.awaited.size() == 0) begin
      $display("PASS midi_track_event_parser");
    end else begin
      $display("FAIL midi_track_event_parser");
    end
    $finish;
  end
endmodule

>>> midi_track_event_parser.f
sv/mtep_pkg.sv
sv/mtep_if.sv
sv/mtep_in_reg.sv
sv/mtep_core.sv
sv/mtep_out_reg.sv
sv/midi_track_event_parser.sv
test/midi_track_event_parser_test.sv
